// ===== src/gbfs_pkg.sv =====
package gbfs_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic       cell_passable;
        logic [4:0] start_row;
        logic [4:0] start_col;
        logic [4:0] goal_row;
        logic [4:0] goal_col;
        logic [9:0] point_index;
    } gbfs_in_t;

    typedef struct packed {
        logic        found;
        logic [10:0] path_length;
        logic [4:0]  point_row;
        logic [4:0]  point_col;
        logic        queue_overflow;
    } gbfs_out_t;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

endpackage

// ===== src/gbfs_ram.sv =====
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/grid_best_first_path_search.sv =====
// Greedy best-first search over a 32 x 32 passability map with four-neighbor moves.
// After reset the block clears the passability and visited maps before it takes
// its first transfer. A map write (mode 0) writes one cell, and a path read (mode 2)
// reads one stored point of the last path. A search (mode 1) first clears the visited
// map. Each pop from the binary heap then walks down the heap level by level, and the
// visited check follows. Each neighbor probe reads the passability map, and each push
// climbs the heap level by level. Tracing the path back stores one point at a time.
// The block takes no new transfer while it works or while a result waits.
module grid_best_first_path_search
    import gbfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gbfs_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output gbfs_out_t m_data
);
    localparam int GD = 32;
    localparam int CELLS = GD * GD;
    localparam int CW = $clog2(CELLS);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int SW = 13;
    // Heap entry: dist(11) seq(SW) row(5) col(5) parent(CW).
    localparam int EW = 11 + SW + 5 + 5 + CW;

    localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_LOAD = 5'd2, S_READ0 = 5'd3,
        S_READ1 = 5'd4, S_SCLR = 5'd5, S_PUSH0 = 5'd6, S_PUSH1 = 5'd7, S_PUSH2 = 5'd8,
        S_POP0 = 5'd9, S_POP1 = 5'd10, S_POP2 = 5'd11, S_POP3 = 5'd12, S_POP4 = 5'd13,
        S_POP5 = 5'd14, S_VIS0 = 5'd15, S_VIS1 = 5'd16, S_NB0 = 5'd17, S_NB1 = 5'd18,
        S_NB2 = 5'd19, S_BP0 = 5'd20, S_BP1 = 5'd21, S_OUT = 5'd22;

    logic [4:0] state_reg;
    gbfs_in_t in_reg;
    logic [CW:0] cnt_reg;
    logic [QW:0] qsize_reg;
    logic [SW-1:0] seq_reg;
    logic [QW-1:0] i_reg, m_reg;
    logic [EW-1:0] e_reg, last_reg, best_reg;
    logic [CW:0] node_reg, pcnt_reg;
    logic [CW-1:0] k_reg, cur_reg;
    logic ovf_reg, found_reg;
    logic [9:0] pt_reg;
    logic [1:0] dir_reg;
    logic [4:0] cr_reg, cc_reg, nr_reg, nc_reg;
    logic [4:0] return_reg;

    // memories
    logic pm_we, pm_wd, pm_rd, vm_we, vm_wd, vm_rd;
    logic [CW-1:0] pm_wa, pm_ra, vm_wa, vm_ra;
    logic q_we;
    logic [QW-1:0] q_wa, q_ra;
    logic [EW-1:0] q_wd, q_rd;
    logic x_we;
    logic [CW-1:0] x_wa, x_ra;
    logic [2*CW-1:0] x_wd, x_rd;
    logic p_we;
    logic [CW-1:0] p_wa, p_ra;
    logic [9:0] p_wd, p_rd;

    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pass (.aclk, .we(pm_we), .waddr(pm_wa),
        .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));
    gbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (.aclk, .we(vm_we), .waddr(vm_wa),
        .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd));
    gbfs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_heap (.aclk, .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
    gbfs_ram #(.WIDTH(2*CW), .DEPTH(CELLS)) u_exp (.aclk, .we(x_we), .waddr(x_wa),
        .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
    gbfs_ram #(.WIDTH(10), .DEPTH(CELLS)) u_path (.aclk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    function automatic logic q_less(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [10+SW:0] ka, kb;
        ka = a[EW-1 -: 11+SW];
        kb = b[EW-1 -: 11+SW];
        return ka < kb;
    endfunction

    // Shared distance unit: one squared difference pair.
    logic [10:0] ddr, ddc;
    logic [10:0] dist_sq;
    always_comb begin
        ddr = (nr_reg >= in_reg.goal_row) ? {6'd0, nr_reg - in_reg.goal_row}
                                           : {6'd0, in_reg.goal_row - nr_reg};
        ddc = (nc_reg >= in_reg.goal_col) ? {6'd0, nc_reg - in_reg.goal_col}
                                           : {6'd0, in_reg.goal_col - nc_reg};
        dist_sq = ddr * ddr + ddc * ddc;
    end

    logic [EW-1:0] new_e;
    assign new_e = {dist_sq, seq_reg, nr_reg, nc_reg, cur_reg};

    logic [QW+1:0] lch, rch, qsize_ext;
    logic [QW-1:0] par;
    assign lch = {1'b0, i_reg, 1'b1};
    assign rch = lch + 1'b1;
    assign par = (i_reg - 1'b1) >> 1;
    assign qsize_ext = {1'b0, qsize_reg};

    logic take_l, take_r;
    assign take_l = (lch < qsize_ext) && q_less(q_rd, last_reg);
    assign take_r = (rch < qsize_ext) && q_less(q_rd, best_reg);

    logic [4:0] e_row, e_col;
    assign e_row = e_reg[CW+9 -: 5];
    assign e_col = e_reg[CW+4 -: 5];

    logic [CW:0] rd_addr;
    assign rd_addr = pcnt_reg - {1'b0, in_reg.point_index} - 1'b1;

    logic signed [6:0] tr, tc;
    always_comb begin
        tr = $signed({2'b0, cr_reg});
        tc = $signed({2'b0, cc_reg});
        case (dir_reg)
            2'd0: tr = tr - 7'sd1;
            2'd1: tr = tr + 7'sd1;
            2'd2: tc = tc - 7'sd1;
            default: tc = tc + 7'sd1;
        endcase
    end
    logic nb_in;
    assign nb_in = (tr >= 0) && (tr < GD) && (tc >= 0) && (tc < GD);

    always_comb begin
        pm_we = 1'b0; pm_wa = cnt_reg[CW-1:0]; pm_wd = 1'b0;
        pm_ra = {tr[4:0], tc[4:0]};
        vm_we = 1'b0; vm_wa = cnt_reg[CW-1:0]; vm_wd = 1'b0;
        vm_ra = {e_row, e_col};
        q_we = 1'b0; q_wa = i_reg; q_wd = e_reg; q_ra = par;
        x_we = 1'b0; x_wa = node_reg[CW-1:0];
        x_wd = {e_row, e_col, e_reg[CW-1:0]}; x_ra = k_reg;
        p_we = 1'b0; p_wa = pcnt_reg[CW-1:0]; p_wd = x_rd[2*CW-1 -: 10];
        p_ra = rd_addr[CW-1:0];
        unique case (state_reg)
            S_CLR: begin pm_we = 1'b1; vm_we = 1'b1; end
            S_SCLR: vm_we = 1'b1;
            S_LOAD: begin
                pm_we = 1'b1; pm_wa = {in_reg.cell_row, in_reg.cell_col};
                pm_wd = in_reg.cell_passable;
            end
            S_PUSH1: q_we = (i_reg == '0);
            S_PUSH2: begin
                q_we = 1'b1;
                if (q_less(e_reg, q_rd)) q_wd = q_rd;
            end
            S_POP0: q_ra = '0;
            S_POP1: q_ra = qsize_reg[QW-1:0];
            S_POP3: q_ra = lch[QW-1:0];
            S_POP4: q_ra = rch[QW-1:0];
            S_POP5: begin
                if (take_r) begin
                    q_we = 1'b1; q_wd = q_rd;
                end else if (m_reg != i_reg) begin
                    q_we = 1'b1; q_wd = best_reg;
                end else if (qsize_reg != '0) begin
                    q_we = 1'b1; q_wd = last_reg;
                end
            end
            S_VIS1: begin
                vm_we = ~vm_rd; vm_wa = {e_row, e_col}; vm_wd = 1'b1;
                x_we = ~vm_rd && (node_reg < CELLS);
            end
            S_BP1: p_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg <= '0;
            m_valid <= 1'b0;
            pcnt_reg <= '0;
            ovf_reg <= 1'b0;
            found_reg <= 1'b0;
            pt_reg <= '0;
        end else begin
            if (state_reg == S_OUT) m_valid <= 1'b1;
            else if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                S_CLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (CW+1)'(CELLS - 1)) state_reg <= S_IDLE;
                end
                S_SCLR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (CW+1)'(CELLS - 1)) begin
                        nr_reg <= in_reg.start_row;
                        nc_reg <= in_reg.start_col;
                        cur_reg <= '0;
                        return_reg <= S_POP0;
                        state_reg <= S_PUSH0;
                    end
                end
                S_IDLE: begin
                    if (s_valid && !m_valid) begin
                        in_reg <= s_data;
                        found_reg <= 1'b0;
                        pt_reg <= '0;
                        unique case (s_data.mode)
                            MODE_LOAD: state_reg <= S_LOAD;
                            MODE_RUN: begin
                                cnt_reg <= '0; qsize_reg <= '0; seq_reg <= '0;
                                node_reg <= '0; pcnt_reg <= '0; ovf_reg <= 1'b0;
                                state_reg <= S_SCLR;
                            end
                            MODE_READ: state_reg <= S_READ0;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end
                S_LOAD: state_reg <= S_OUT;
                S_READ0: state_reg <= S_READ1;
                S_READ1: begin
                    if ({1'b0, in_reg.point_index} < pcnt_reg) begin
                        found_reg <= 1'b1;
                        pt_reg <= p_rd;
                    end
                    state_reg <= S_OUT;
                end
                S_PUSH0: begin
                    if (qsize_reg == (QW+1)'(QUEUE_DEPTH)) begin
                        ovf_reg <= 1'b1;
                        state_reg <= return_reg;
                    end else begin
                        e_reg <= new_e;
                        seq_reg <= seq_reg + 1'b1;
                        i_reg <= qsize_reg[QW-1:0];
                        qsize_reg <= qsize_reg + 1'b1;
                        state_reg <= S_PUSH1;
                    end
                end
                S_PUSH1: begin
                    if (i_reg == '0) state_reg <= return_reg;
                    else state_reg <= S_PUSH2;
                end
                S_PUSH2: begin
                    if (q_less(e_reg, q_rd)) begin
                        i_reg <= par;
                        state_reg <= S_PUSH1;
                    end else state_reg <= return_reg;
                end
                S_POP0: begin
                    if (qsize_reg == '0) state_reg <= S_OUT;
                    else begin
                        qsize_reg <= qsize_reg - 1'b1;
                        state_reg <= S_POP1;
                    end
                end
                S_POP1: begin
                    e_reg <= q_rd; i_reg <= '0; state_reg <= S_POP2;
                end
                S_POP2: begin last_reg <= q_rd; state_reg <= S_POP3; end
                S_POP3: state_reg <= S_POP4;
                S_POP4: begin
                    if (take_l) begin
                        best_reg <= q_rd; m_reg <= lch[QW-1:0];
                    end else begin
                        best_reg <= last_reg; m_reg <= i_reg;
                    end
                    state_reg <= S_POP5;
                end
                S_POP5: begin
                    if (take_r) begin
                        i_reg <= rch[QW-1:0];
                        state_reg <= S_POP3;
                    end else if (m_reg != i_reg) begin
                        i_reg <= m_reg;
                        state_reg <= S_POP3;
                    end else state_reg <= S_VIS0;
                end
                S_VIS0: state_reg <= S_VIS1;
                S_VIS1: begin
                    if (vm_rd) state_reg <= S_POP0;
                    else if (node_reg >= CELLS) state_reg <= S_OUT;
                    else if (e_row == in_reg.goal_row && e_col == in_reg.goal_col) begin
                        found_reg <= 1'b1;
                        k_reg <= node_reg[CW-1:0];
                        node_reg <= node_reg + 1'b1;
                        state_reg <= S_BP0;
                    end else begin
                        cur_reg <= node_reg[CW-1:0];
                        node_reg <= node_reg + 1'b1;
                        cr_reg <= e_row; cc_reg <= e_col; dir_reg <= 2'd0;
                        state_reg <= S_NB0;
                    end
                end
                S_NB0: state_reg <= S_NB1;
                S_NB1: begin
                    if (nb_in && pm_rd) begin
                        nr_reg <= tr[4:0]; nc_reg <= tc[4:0];
                        return_reg <= S_NB2;
                        state_reg <= S_PUSH0;
                    end else state_reg <= S_NB2;
                end
                S_NB2: begin
                    if (dir_reg == 2'd3) state_reg <= S_POP0;
                    else begin dir_reg <= dir_reg + 1'b1; state_reg <= S_NB0; end
                end
                S_BP0: state_reg <= (k_reg == '0) ? S_OUT : S_BP1;
                S_BP1: begin
                    pcnt_reg <= pcnt_reg + 1'b1;
                    k_reg <= x_rd[CW-1:0];
                    state_reg <= S_BP0;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign m_data = '{found: found_reg, path_length: pcnt_reg,
        point_row: pt_reg[9:5], point_col: pt_reg[4:0], queue_overflow: ovf_reg};
endmodule

// ===== src/gbfs_checker.sv =====
module gbfs_checker
    import gbfs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input gbfs_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken with result pending");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready right after a transfer");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.path_length <= 11'd1024) else $error("path too long");
endmodule

bind grid_best_first_path_search gbfs_checker u_chk (.aclk, .aresetn, .s_valid, .s_ready,
    .m_valid, .m_ready, .m_data);
